// ===== rtl/rlbd_pkg.sv =====
package rlbd_pkg;

	localparam int MAX_BANDS = 8;
	localparam int BAND_IDX_W = $clog2(MAX_BANDS);
	localparam int SAMPLE_W = 12;
	localparam int TIME_W = 32;
	localparam int DEBOUNCE_W = 16;
	localparam int COUNT_W = 4;
	localparam int TYPE_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 56;

	localparam logic [SAMPLE_W-1:0] LOW_LIMIT = 12'd800;
	localparam logic [SAMPLE_W-1:0] HIGH_LIMIT = 12'd4090;
	localparam logic [SAMPLE_W-1:0] STABLE_TOL = 12'd100;

	// ceil(2^16 / 3): exact floor(s / 3) for s below 2^15
	localparam logic [14:0] RECIP3 = 15'd21846;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE   = 3'd0,
		CFG_BAND_COUNT = 3'd1,
		CFG_PAIR_0     = 3'd2,
		CFG_PAIR_1     = 3'd3,
		CFG_PAIR_2     = 3'd4,
		CFG_PAIR_3     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [TYPE_W-1:0]   btype;
		logic [SAMPLE_W-1:0] hi;
		logic [SAMPLE_W-1:0] lo;
	} band_t;

	typedef struct packed {
		logic [DEBOUNCE_W-1:0]     debounce;
		logic [COUNT_W-1:0]        band_count;
		band_t [MAX_BANDS-1:0]     bands;
	} cfg_t;

	// classified transaction handed from front to back
	typedef struct packed {
		logic                  idle;
		logic                  hit;
		logic                  stable;
		logic [BAND_IDX_W-1:0] idx;
		logic [TYPE_W-1:0]     btype;
		logic [SAMPLE_W-1:0]   value;
		logic [TIME_W-1:0]     now;
	} item_t;

endpackage

// ===== rtl/rlbd_front.sv =====
module rlbd_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rlbd_pkg::cfg_t                   cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rlbd_pkg::SAMPLE_W-1:0]    sample_a,
	input  logic [rlbd_pkg::SAMPLE_W-1:0]    sample_b,
	input  logic [rlbd_pkg::SAMPLE_W-1:0]    sample_c,
	input  logic [rlbd_pkg::SAMPLE_W-1:0]    recheck_a,
	input  logic [rlbd_pkg::SAMPLE_W-1:0]    recheck_b,
	input  logic [rlbd_pkg::SAMPLE_W-1:0]    recheck_c,
	input  logic [rlbd_pkg::TIME_W-1:0]      now_ms,
	output logic                             push_valid,
	input  logic                             push_ready,
	output rlbd_pkg::item_t                  push_item
);

	logic [13:0]                      main_sum;
	logic [13:0]                      conf_sum;
	logic [28:0]                      main_prod;
	logic [28:0]                      conf_prod;
	logic                             v_s1;
	logic [rlbd_pkg::SAMPLE_W-1:0]    main_avg_s1;
	logic [rlbd_pkg::SAMPLE_W-1:0]    conf_avg_s1;
	logic [rlbd_pkg::TIME_W-1:0]      now_s1;
	logic [rlbd_pkg::SAMPLE_W-1:0]    diff;
	logic [rlbd_pkg::MAX_BANDS-1:0]   match;

	assign main_sum = 14'(sample_a) + 14'(sample_b) + 14'(sample_c);
	assign conf_sum = 14'(recheck_a) + 14'(recheck_b) + 14'(recheck_c);
	assign main_prod = 29'(main_sum) * 29'(rlbd_pkg::RECIP3);
	assign conf_prod = 29'(conf_sum) * 29'(rlbd_pkg::RECIP3);

	assign in_ready = !v_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			main_avg_s1 <= main_prod[27:16];
			conf_avg_s1 <= conf_prod[27:16];
			now_s1 <= now_ms;
		end
	end

	always_comb begin
		for (int i = 0; i < rlbd_pkg::MAX_BANDS; i++) begin
			match[i] = (int'(cfg.band_count) > i)
				&& (main_avg_s1 >= cfg.bands[i].lo)
				&& (main_avg_s1 <= cfg.bands[i].hi);
		end
	end

	assign diff = (main_avg_s1 > conf_avg_s1) ? (main_avg_s1 - conf_avg_s1)
		: (conf_avg_s1 - main_avg_s1);

	always_comb begin
		push_item = '0;
		push_item.idle = (main_avg_s1 <= rlbd_pkg::LOW_LIMIT)
			|| (main_avg_s1 >= rlbd_pkg::HIGH_LIMIT);
		push_item.stable = (diff <= rlbd_pkg::STABLE_TOL);
		push_item.value = main_avg_s1;
		push_item.now = now_s1;
		// lowest matching band wins
		for (int i = rlbd_pkg::MAX_BANDS - 1; i >= 0; i--) begin
			if (match[i]) begin
				push_item.hit = 1'b1;
				push_item.idx = rlbd_pkg::BAND_IDX_W'(i);
				push_item.btype = cfg.bands[i].btype;
			end
		end
	end

	assign push_valid = v_s1;

endmodule

// ===== rtl/rlbd_queue.sv =====
module rlbd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  rlbd_pkg::item_t  push_item,
	output logic             pop_valid,
	input  logic             pop_ready,
	output rlbd_pkg::item_t  pop_item
);

	rlbd_pkg::item_t                 mem [rlbd_pkg::Q_DEPTH];
	logic [rlbd_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [rlbd_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [rlbd_pkg::Q_CNT_W-1:0]    count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = (count_q != rlbd_pkg::Q_CNT_W'(rlbd_pkg::Q_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_item = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == rlbd_pkg::Q_PTR_W'(rlbd_pkg::Q_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == rlbd_pkg::Q_PTR_W'(rlbd_pkg::Q_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rlbd_pkg::Q_CNT_W'(rlbd_pkg::Q_DEPTH))
		else $error("queue count over depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow push");

endmodule

// ===== rtl/rlbd_back.sv =====
module rlbd_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [rlbd_pkg::DEBOUNCE_W-1:0]    debounce,
	input  logic                               pop_valid,
	output logic                               pop_ready,
	input  rlbd_pkg::item_t                    pop_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               press_event,
	output logic [rlbd_pkg::BAND_IDX_W-1:0]    band_index,
	output logic [rlbd_pkg::TYPE_W-1:0]        last_type,
	output logic [rlbd_pkg::SAMPLE_W-1:0]      last_value,
	output logic                               held_flag
);

	logic                               out_valid_q;
	logic                               event_q;
	logic [rlbd_pkg::BAND_IDX_W-1:0]    idx_q;
	logic                               latch_q;
	logic [rlbd_pkg::TIME_W-1:0]        last_time_q;
	logic [rlbd_pkg::TYPE_W-1:0]        type_q;
	logic [rlbd_pkg::SAMPLE_W-1:0]      value_q;
	logic                               take;
	logic [rlbd_pkg::TIME_W-1:0]        elapsed;
	logic                               settled;
	logic                               fire;

	assign pop_ready = !out_valid_q || out_ready;
	assign take = pop_valid && pop_ready;
	assign elapsed = pop_item.now - last_time_q;
	assign settled = elapsed > rlbd_pkg::TIME_W'(debounce);
	assign fire = !pop_item.idle && settled && pop_item.hit && !latch_q && pop_item.stable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			event_q <= 1'b0;
			idx_q <= '0;
			latch_q <= 1'b0;
			last_time_q <= '0;
			type_q <= '0;
			value_q <= '0;
		end else begin
			if (pop_ready) begin
				out_valid_q <= pop_valid;
			end
			if (take) begin
				event_q <= fire;
				idx_q <= fire ? pop_item.idx : '0;
				if (pop_item.idle) begin
					latch_q <= 1'b0;
				end else if (fire) begin
					latch_q <= 1'b1;
					last_time_q <= pop_item.now;
					type_q <= pop_item.btype;
					value_q <= pop_item.value;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign press_event = event_q;
	assign band_index = idx_q;
	assign last_type = type_q;
	assign last_value = value_q;
	assign held_flag = latch_q;

	a_event_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && event_q) |-> latch_q)
		else $error("event without latch");

	a_idx_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !event_q) |-> idx_q == '0)
		else $error("band index set without event");

	a_time_rec: assert property (@(posedge clk) disable iff (!arst_n)
		(take && fire) |=> last_time_q == $past(pop_item.now))
		else $error("accept time not recorded");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && pop_item.idle) |=> !latch_q && !event_q)
		else $error("idle line did not clear latch");

endmodule

// ===== rtl/resistor_ladder_button_decoder.sv =====
// channel | valid     | ready     | payload
// in      | in_valid  | in_ready  | sample_a/b/c, recheck_a/b/c, now_ms
// out     | out_valid | out_ready | press_event, band_index, last_type, last_value, held_flag
// cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// One transaction per clock sustained while out_ready is high. Path from input to result:
// averaging multiply register, two-entry queue, then the state/output register.
// The queue lets front and back stall independently; cfg_ready is always high.
// arst_n clears latch, accept time, recorded type/value and all config registers.
module resistor_ladder_button_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rlbd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rlbd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rlbd_pkg::SAMPLE_W-1:0]      sample_a,
	input  logic [rlbd_pkg::SAMPLE_W-1:0]      sample_b,
	input  logic [rlbd_pkg::SAMPLE_W-1:0]      sample_c,
	input  logic [rlbd_pkg::SAMPLE_W-1:0]      recheck_a,
	input  logic [rlbd_pkg::SAMPLE_W-1:0]      recheck_b,
	input  logic [rlbd_pkg::SAMPLE_W-1:0]      recheck_c,
	input  logic [rlbd_pkg::TIME_W-1:0]        now_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               press_event,
	output logic [rlbd_pkg::BAND_IDX_W-1:0]    band_index,
	output logic [rlbd_pkg::TYPE_W-1:0]        last_type,
	output logic [rlbd_pkg::SAMPLE_W-1:0]      last_value,
	output logic                               held_flag
);

	rlbd_pkg::cfg_t   cfg_q;
	rlbd_pkg::item_t  push_item;
	rlbd_pkg::item_t  pop_item;
	logic             push_valid;
	logic             push_ready;
	logic             pop_valid;
	logic             pop_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rlbd_pkg::CFG_DEBOUNCE: begin
					cfg_q.debounce <= cfg_data[rlbd_pkg::DEBOUNCE_W-1:0];
				end
				rlbd_pkg::CFG_BAND_COUNT: begin
					cfg_q.band_count <= cfg_data[rlbd_pkg::COUNT_W-1:0];
				end
				rlbd_pkg::CFG_PAIR_0: begin
					cfg_q.bands[0] <= cfg_data[27:0];
					cfg_q.bands[1] <= cfg_data[55:28];
				end
				rlbd_pkg::CFG_PAIR_1: begin
					cfg_q.bands[2] <= cfg_data[27:0];
					cfg_q.bands[3] <= cfg_data[55:28];
				end
				rlbd_pkg::CFG_PAIR_2: begin
					cfg_q.bands[4] <= cfg_data[27:0];
					cfg_q.bands[5] <= cfg_data[55:28];
				end
				rlbd_pkg::CFG_PAIR_3: begin
					cfg_q.bands[6] <= cfg_data[27:0];
					cfg_q.bands[7] <= cfg_data[55:28];
				end
				default: begin
				end
			endcase
		end
	end

	rlbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_a   (sample_a),
		.sample_b   (sample_b),
		.sample_c   (sample_c),
		.recheck_a  (recheck_a),
		.recheck_b  (recheck_b),
		.recheck_c  (recheck_c),
		.now_ms     (now_ms),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	rlbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	rlbd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.debounce    (cfg_q.debounce),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.press_event (press_event),
		.band_index  (band_index),
		.last_type   (last_type),
		.last_value  (last_value),
		.held_flag   (held_flag)
	);

endmodule
